// ===== sv/dmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// dmcs_pkg: shared types and constants for the disk minimax center search
// Widths of coordinates, radius and gap, reset values, controller commands.
// ----------------------------------------------------------------------------
package dmcs_pkg;

    localparam int MAX_DISKS_DEF = 1024;
    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W = 27;
    localparam int RADIUS_W = 26;
    localparam int GAP_W = 28;
    localparam int ITER_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_COUNT = 2'd2;

    localparam logic signed [COORD_W-1:0] WINDOW_LOW_RST = -27'sd65536000;
    localparam logic signed [COORD_W-1:0] WINDOW_HIGH_RST = 27'sd65536000;
    localparam logic [ITER_W-1:0] ITER_COUNT_RST = 8'd100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_x;     // x interval := window
        logic init_y;     // y interval := window
        logic load_px;    // px := probe of x (sel_x picks m1, m2 or l)
        logic [1:0] sel_x;
        logic [1:0] sel_y;
        logic eval_start; // start one worst gap evaluation at (px, probe y)
        logic take_g1;    // store y-eval result as first probe
        logic step_y;     // update y interval from g1 vs last eval
        logic take_h1;    // store y-search result as first x probe
        logic step_x;     // update x interval from h1 vs last y result
        logic take_ysr;   // last eval is the y search result
    } dmcs_cmd_t;

    typedef struct packed {
        logic eval_done;
    } dmcs_sts_t;

    localparam logic [1:0] SEL_M1 = 2'd0;
    localparam logic [1:0] SEL_M2 = 2'd1;
    localparam logic [1:0] SEL_L = 2'd2;

endpackage

// ===== sv/dmcs_datapath.sv =====
// ----------------------------------------------------------------------------
// dmcs_datapath: disk store, worst gap evaluator and ternary intervals
// Walks the stored disks one per pass with a sequential square root.
// ----------------------------------------------------------------------------
module dmcs_datapath #(
    parameter int MAX_DISKS = dmcs_pkg::MAX_DISKS_DEF,
    parameter int CNT_W = $clog2(MAX_DISKS + 1),
    parameter int ADDR_W = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic signed [dmcs_pkg::COORD_W-1:0] wr_x,
    input  logic signed [dmcs_pkg::COORD_W-1:0] wr_y,
    input  logic [dmcs_pkg::RADIUS_W-1:0] wr_r,
    input  logic [CNT_W-1:0] count,
    input  logic signed [dmcs_pkg::COORD_W-1:0] win_low,
    input  logic signed [dmcs_pkg::COORD_W-1:0] win_high,
    input  dmcs_pkg::dmcs_cmd_t cmd,
    output dmcs_pkg::dmcs_sts_t sts,
    output logic [dmcs_pkg::GAP_W-1:0] y_result
);
    localparam int CW = dmcs_pkg::COORD_W;
    localparam int DW = CW + 2;          // coordinate differences
    localparam int SQ_W = 2 * DW;        // squared distance
    localparam int RT_W = DW + 1;        // root

    logic signed [CW-1:0] mem_x [MAX_DISKS];
    logic signed [CW-1:0] mem_y [MAX_DISKS];
    logic [dmcs_pkg::RADIUS_W-1:0] mem_r [MAX_DISKS];
    logic signed [CW-1:0] rd_x_reg, rd_y_reg;
    logic [dmcs_pkg::RADIUS_W-1:0] rd_r_reg;
    logic [ADDR_W-1:0] rd_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
            mem_r[wr_addr] <= wr_r;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
        rd_r_reg <= mem_r[rd_addr];
    end

    // ternary intervals
    logic signed [CW-1:0] xl_reg, xr_reg, yl_reg, yr_reg, px_reg, py_reg;
    logic signed [CW:0] xthird, ythird;
    logic signed [CW-1:0] xm1, xm2, ym1, ym2, ysel;
    logic [dmcs_pkg::GAP_W-1:0] g1_reg, h1_reg, ysr_reg, best_reg;

    function automatic logic signed [CW:0] third_of(input logic signed [CW:0] d);
        logic [CW:0] a;
        logic [CW+30:0] p;
        logic [CW:0] q;
        begin
            a = d[CW] ? -d : d;
            // floor(a/3) via reciprocal, exact for a below 2^29
            p = {30'd0, a} * (CW+31)'(29'd357913942);
            q = (CW + 1)'(p >> 30);
            third_of = d[CW] ? -$signed(q) : $signed(q);
        end
    endfunction

    assign xthird = third_of($signed({xr_reg[CW-1], xr_reg}) - $signed({xl_reg[CW-1], xl_reg}));
    assign ythird = third_of($signed({yr_reg[CW-1], yr_reg}) - $signed({yl_reg[CW-1], yl_reg}));
    assign xm1 = CW'(xl_reg + xthird);
    assign xm2 = CW'(xr_reg - xthird);
    assign ym1 = CW'(yl_reg + ythird);
    assign ym2 = CW'(yr_reg - ythird);

    always_comb
    begin
        case (cmd.sel_y)
            dmcs_pkg::SEL_M1: ysel = ym1;
            dmcs_pkg::SEL_M2: ysel = ym2;
            default: ysel = yl_reg;
        endcase
    end

    // evaluator: phases FETCH, DIFF, SQ, ROOT, ACC
    typedef enum logic [2:0] {E_IDLE, E_FETCH, E_DIFF, E_SQ, E_ROOT, E_ACC} ev_t;
    ev_t ev_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [DW-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0] sq_reg, sqx_reg;
    logic [SQ_W-1:0] rem_reg;
    logic [RT_W-1:0] res_reg;
    logic [5:0] step_reg;
    logic [dmcs_pkg::RADIUS_W-1:0] r_hold_reg;
    logic done_reg;
    logic signed [DW-1:0] ddx, ddy;

    assign rd_addr = ADDR_W'(idx_reg);
    assign ddx = DW'(px_reg) - DW'(rd_x_reg);
    assign ddy = DW'(py_reg) - DW'(rd_y_reg);

    // restoring root, two bits a step
    logic [SQ_W+1:0] rem_sh, tst;
    logic [RT_W+1:0] res4;
    always_comb
    begin
        rem_sh = {rem_reg, 2'b00} | (SQ_W+2)'(sq_reg[SQ_W-1 -: 2]);
        res4 = {res_reg, 2'b01};
        tst = (SQ_W+2)'(res4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= E_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (ev_reg)
                E_IDLE:
                begin
                    if (cmd.eval_start)
                    begin
                        idx_reg <= '0;
                        best_reg <= '0;
                        py_reg <= ysel;
                        ev_reg <= (count == 0) ? E_ACC : E_FETCH;
                    end
                end
                E_FETCH: ev_reg <= E_DIFF;
                E_DIFF:
                begin
                    dx_reg <= ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
                    dy_reg <= ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
                    r_hold_reg <= rd_r_reg;
                    ev_reg <= E_SQ;
                end
                E_SQ:
                begin
                    // two squares, one multiplier each, registered
                    sqx_reg <= SQ_W'(dx_reg * dx_reg);
                    sq_reg <= SQ_W'(dy_reg * dy_reg);
                    step_reg <= '0;
                    rem_reg <= '0;
                    res_reg <= '0;
                    ev_reg <= E_ROOT;
                end
                E_ROOT:
                begin
                    if (step_reg == 0 && res_reg == 0 && rem_reg == 0 && sqx_reg != 0)
                    begin
                        sq_reg <= sq_reg + sqx_reg;
                        sqx_reg <= '0;
                    end
                    else
                    begin
                        if (rem_sh >= tst)
                        begin
                            rem_reg <= SQ_W'(rem_sh - tst);
                            res_reg <= {res_reg[RT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= SQ_W'(rem_sh);
                            res_reg <= {res_reg[RT_W-2:0], 1'b0};
                        end
                        sq_reg <= {sq_reg[SQ_W-3:0], 2'b00};
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 6'(SQ_W / 2 - 1))
                            ev_reg <= E_ACC;
                    end
                end
                default:
                begin
                    if (count != 0)
                    begin
                        if (res_reg >= RT_W'(r_hold_reg) &&
                            (res_reg - RT_W'(r_hold_reg)) > RT_W'(best_reg))
                            best_reg <= dmcs_pkg::GAP_W'(res_reg - RT_W'(r_hold_reg));
                    end
                    if (count != 0 && idx_reg + 1'b1 < count)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        ev_reg <= E_FETCH;
                    end
                    else
                    begin
                        ev_reg <= E_IDLE;
                        done_reg <= 1'b1;
                    end
                end
            endcase
        end
    end

    assign sts.eval_done = done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.init_x)
        begin
            xl_reg <= win_low;
            xr_reg <= win_high;
        end
        if (cmd.init_y)
        begin
            yl_reg <= win_low;
            yr_reg <= win_high;
        end
        if (cmd.load_px)
        begin
            case (cmd.sel_x)
                dmcs_pkg::SEL_M1: px_reg <= xm1;
                dmcs_pkg::SEL_M2: px_reg <= xm2;
                default: px_reg <= xl_reg;
            endcase
        end
        if (cmd.take_g1)
            g1_reg <= best_reg;
        if (cmd.step_y)
        begin
            if (g1_reg > best_reg)
                yl_reg <= ym1;
            else
                yr_reg <= ym2;
        end
        if (cmd.take_ysr)
            ysr_reg <= best_reg;
        if (cmd.take_h1)
            h1_reg <= ysr_reg;
        if (cmd.step_x)
        begin
            if (h1_reg > ysr_reg)
                xl_reg <= xm1;
            else
                xr_reg <= xm2;
        end
    end

    assign y_result = ysr_reg;

endmodule

// ===== sv/dmcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmcs_ctrl: nested ternary search sequencer
// Steps the x and y searches and issues one gap evaluation at a time.
// ----------------------------------------------------------------------------
module dmcs_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [dmcs_pkg::ITER_W-1:0] iters,
    input  dmcs_pkg::dmcs_sts_t sts,
    output dmcs_pkg::dmcs_cmd_t cmd,
    output logic done
);
    typedef enum logic [3:0] {
        S_IDLE, S_XPROBE, S_YINIT, S_YE1, S_YW1, S_YE2, S_YW2, S_YFIN, S_YWF,
        S_XAFTER, S_DONE
    } state_t;

    state_t state_reg;
    logic [dmcs_pkg::ITER_W-1:0] xk_reg, yk_reg;
    logic [1:0] xph_reg; // which x probe: m1, m2, final l

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            xk_reg <= '0;
            yk_reg <= '0;
            xph_reg <= dmcs_pkg::SEL_M1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        xk_reg <= '0;
                        xph_reg <= (iters == 0) ? dmcs_pkg::SEL_L : dmcs_pkg::SEL_M1;
                        state_reg <= S_XPROBE;
                    end
                S_XPROBE: state_reg <= S_YINIT;
                S_YINIT:
                begin
                    yk_reg <= '0;
                    state_reg <= (iters == 0) ? S_YFIN : S_YE1;
                end
                S_YE1: state_reg <= S_YW1;
                S_YW1: if (sts.eval_done) state_reg <= S_YE2;
                S_YE2: state_reg <= S_YW2;
                S_YW2:
                    if (sts.eval_done)
                    begin
                        yk_reg <= yk_reg + 1'b1;
                        state_reg <= (yk_reg + 1'b1 == iters) ? S_YFIN : S_YE1;
                    end
                S_YFIN: state_reg <= S_YWF;
                S_YWF: if (sts.eval_done) state_reg <= S_XAFTER;
                S_XAFTER:
                begin
                    if (xph_reg == dmcs_pkg::SEL_M1)
                    begin
                        xph_reg <= dmcs_pkg::SEL_M2;
                        state_reg <= S_XPROBE;
                    end
                    else if (xph_reg == dmcs_pkg::SEL_M2)
                    begin
                        xk_reg <= xk_reg + 1'b1;
                        xph_reg <= (xk_reg + 1'b1 == iters) ? dmcs_pkg::SEL_L
                                                            : dmcs_pkg::SEL_M1;
                        state_reg <= S_XPROBE;
                    end
                    else
                        state_reg <= S_DONE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.sel_x = xph_reg;
        cmd.sel_y = dmcs_pkg::SEL_L;
        cmd.init_x = (state_reg == S_IDLE) && start;
        cmd.load_px = (state_reg == S_XPROBE);
        cmd.init_y = (state_reg == S_XPROBE);
        case (state_reg)
            S_YE1: begin cmd.eval_start = 1'b1; cmd.sel_y = dmcs_pkg::SEL_M1; end
            S_YE2: begin cmd.eval_start = 1'b1; cmd.sel_y = dmcs_pkg::SEL_M2; end
            S_YFIN: cmd.eval_start = 1'b1;
            default: ;
        endcase
        cmd.take_g1 = (state_reg == S_YW1) && sts.eval_done;
        cmd.step_y = (state_reg == S_YW2) && sts.eval_done;
        cmd.take_ysr = (state_reg == S_YWF) && sts.eval_done;
        cmd.take_h1 = (state_reg == S_XAFTER) && (xph_reg == dmcs_pkg::SEL_M1);
        cmd.step_x = (state_reg == S_XAFTER) && (xph_reg == dmcs_pkg::SEL_M2);
    end

    assign done = (state_reg == S_DONE);

endmodule

// ===== sv/disk_minimax_center_search.sv =====
// ----------------------------------------------------------------------------
// disk_minimax_center_search: minimax disk center search
// Loads disks, then finds the window point minimizing the largest edge gap.
// ----------------------------------------------------------------------------
// Disks enter one per input transaction and are written to a store of
// MAX_DISKS entries; extra disks are dropped and flagged. The transaction
// that carries last_disk starts a nested ternary search: (2N+1) x probes,
// each a y search of (2N+1) gap evaluations, N being iteration_count. One
// gap evaluation walks the stored disks one at a time through a bit-serial
// square root. A single disk gives 0 at once. The input accepts nothing
// while a search runs or while a result waits; the result sits in an
// output register until taken.
// ----------------------------------------------------------------------------
module disk_minimax_center_search #(
    parameter int MAX_DISKS = dmcs_pkg::MAX_DISKS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [dmcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmcs_pkg::COORD_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [dmcs_pkg::COORD_W-1:0] center_x,
    input  logic signed [dmcs_pkg::COORD_W-1:0] center_y,
    input  logic [dmcs_pkg::RADIUS_W-1:0] disk_radius,
    input  logic last_disk,
    output logic out_valid,
    input  logic out_ready,
    output logic [dmcs_pkg::GAP_W-1:0] min_max_gap,
    output logic overflowed
);
    localparam int CNT_W = $clog2(MAX_DISKS + 1);
    localparam int ADDR_W = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;

    logic signed [dmcs_pkg::COORD_W-1:0] win_low_reg, win_high_reg;
    logic [dmcs_pkg::ITER_W-1:0] iters_reg;
    logic [CNT_W-1:0] count_reg;
    logic ovf_reg, busy_reg, start_reg;
    logic in_acc, wr_en, done;
    dmcs_pkg::dmcs_cmd_t cmd;
    dmcs_pkg::dmcs_sts_t sts;
    logic [dmcs_pkg::GAP_W-1:0] y_result;

    // Configuration writes; unused index ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg <= dmcs_pkg::WINDOW_LOW_RST;
            win_high_reg <= dmcs_pkg::WINDOW_HIGH_RST;
            iters_reg <= dmcs_pkg::ITER_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dmcs_pkg::CFG_WINDOW_LOW: win_low_reg <= cfg_data;
                dmcs_pkg::CFG_WINDOW_HIGH: win_high_reg <= cfg_data;
                dmcs_pkg::CFG_ITER_COUNT: iters_reg <= cfg_data[dmcs_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the input while searching or while a result waits.
    assign in_ready = !busy_reg && !out_valid;
    assign in_acc = in_valid && in_ready;
    assign wr_en = in_acc && (count_reg < CNT_W'(MAX_DISKS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg <= 1'b0;
            busy_reg <= 1'b0;
            start_reg <= 1'b0;
            out_valid <= 1'b0;
            min_max_gap <= '0;
            overflowed <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (in_acc)
            begin
                if (wr_en)
                    count_reg <= count_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
                if (last_disk)
                begin
                    // one stored disk: answer at once
                    if ((wr_en && count_reg == 0) || (!wr_en && count_reg == CNT_W'(1)))
                    begin
                        out_valid <= 1'b1;
                        min_max_gap <= '0;
                        overflowed <= ovf_reg || !wr_en;
                        count_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                    else
                    begin
                        busy_reg <= 1'b1;
                        start_reg <= 1'b1;
                    end
                end
            end
            if (busy_reg && done)
            begin
                busy_reg <= 1'b0;
                out_valid <= 1'b1;
                min_max_gap <= y_result;
                overflowed <= ovf_reg;
                count_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    dmcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .iters (iters_reg),
        .sts   (sts),
        .cmd   (cmd),
        .done  (done)
    );

    dmcs_datapath #(
        .MAX_DISKS (MAX_DISKS),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (ADDR_W'(count_reg)),
        .wr_x     (center_x),
        .wr_y     (center_y),
        .wr_r     (disk_radius),
        .count    (count_reg),
        .win_low  (win_low_reg),
        .win_high (win_high_reg),
        .cmd      (cmd),
        .sts      (sts),
        .y_result (y_result)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DISKS)) else $error("disk count past store size");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ready) else $error("input accepted during search");
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && done) |=> out_valid) else $error("search result lost");

endmodule
